// ----- rtl/psls_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// psls_pkg
// Shared types and constants for the prefix sum lower bound search core.
// ============================================================================
package psls_pkg;

    localparam int MAX_SEGMENTS = 1024;
    localparam int ADDR_W       = $clog2(MAX_SEGMENTS);
    localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
    localparam int IDX_W        = 11;
    localparam int SUM_W        = 48;
    localparam int LEN_W        = 16;
    localparam int PROD_W       = 2 * LEN_W;
    localparam int MODE_W       = 2;
    localparam int Q_DEPTH      = 2;
    localparam int Q_PTR_W      = $clog2(Q_DEPTH);
    localparam int Q_CNT_W      = $clog2(Q_DEPTH + 1);

    localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
    localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        OP_APPEND,
        OP_QUERY,
        OP_CLEAR
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [PROD_W-1:0] product;
        logic [SUM_W-1:0]  key;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

// ----- rtl/psls_front.sv -----
`timescale 1ns / 1ps
// ============================================================================
// psls_front
// Accepts requests, decodes the mode and forms the segment product.
// ============================================================================
module psls_front
    import psls_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [MODE_W-1:0] mode,
    input  logic [LEN_W-1:0]  play_count,
    input  logic [LEN_W-1:0]  segment_length,
    input  logic [SUM_W-1:0]  query_minute,
    input  q_stat_t           q_stat,
    output logic              push,
    output cmd_t              cmd
);

    logic valid_reg;
    logic valid_next;
    cmd_t cmd_reg;
    cmd_t cmd_next;
    logic accept;
    logic keep;
    op_t  op_dec;

    assign busy   = valid_reg & q_stat.full;
    assign accept = start & ~busy;
    assign push   = valid_reg & ~q_stat.full;
    assign cmd    = cmd_reg;

    always_comb
    begin
        op_dec = OP_CLEAR;
        keep   = 1'b1;
        unique case (mode)
            MODE_APPEND: op_dec = OP_APPEND;
            MODE_QUERY:  op_dec = OP_QUERY;
            MODE_CLEAR:  op_dec = OP_CLEAR;
            MODE_UNUSED: keep   = 1'b0;
            default:     keep   = 1'b0;
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        cmd_next   = cmd_reg;
        if (push)
        begin
            valid_next = 1'b0;
        end
        if (accept)
        begin
            valid_next       = keep;
            cmd_next.op      = op_dec;
            cmd_next.product = PROD_W'(play_count) * PROD_W'(segment_length);
            cmd_next.key     = query_minute;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

endmodule

// ----- rtl/psls_queue.sv -----
`timescale 1ns / 1ps
// ============================================================================
// psls_queue
// Short command queue between the front decoder and the execution unit.
// ============================================================================
module psls_queue
    import psls_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  cmd_t    push_cmd,
    input  logic    pop,
    output cmd_t    head,
    output q_stat_t q_stat
);

    cmd_t                entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]  wr_ptr_reg;
    logic [Q_PTR_W-1:0]  wr_ptr_next;
    logic [Q_PTR_W-1:0]  rd_ptr_reg;
    logic [Q_PTR_W-1:0]  rd_ptr_next;
    logic [Q_CNT_W-1:0]  count_reg;
    logic [Q_CNT_W-1:0]  count_next;
    logic                do_push;
    logic                do_pop;

    assign q_stat.full  = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign do_push      = push & ~q_stat.full;
    assign do_pop       = pop & ~q_stat.empty;
    assign head         = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- rtl/psls_back.sv -----
`timescale 1ns / 1ps
// ============================================================================
// psls_back
// Execution unit: keeps the prefix sum table and runs the binary search.
// ============================================================================
module psls_back
    import psls_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cmd_t             head,
    input  q_stat_t          q_stat,
    output logic             pop,
    output logic             done,
    output logic [IDX_W-1:0] segment_index
);

    typedef enum logic {
        ST_IDLE,
        ST_SEARCH
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [SUM_W-1:0]   total_reg;
    logic [SUM_W-1:0]   total_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [CNT_W-1:0]   lo_reg;
    logic [CNT_W-1:0]   lo_next;
    logic [CNT_W-1:0]   hi_reg;
    logic [CNT_W-1:0]   hi_next;
    logic [CNT_W-1:0]   mid_reg;
    logic [CNT_W-1:0]   mid_next;
    logic [SUM_W-1:0]   key_reg;
    logic [SUM_W-1:0]   key_next;
    logic               done_reg;
    logic               done_next;
    logic [IDX_W-1:0]   index_reg;
    logic [IDX_W-1:0]   index_next;

    logic [SUM_W-1:0]   mem [MAX_SEGMENTS];
    logic [SUM_W-1:0]   rd_data_reg;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [SUM_W-1:0]   wr_data;

    logic [SUM_W:0]     sum;
    logic               less;
    logic [CNT_W-1:0]   lo_step;
    logic [CNT_W-1:0]   hi_step;
    logic [CNT_W-1:0]   mid_step;
    logic [CNT_W:0]     lo_plus;

    assign done          = done_reg;
    assign segment_index = index_reg;

    always_comb
    begin
        sum      = {1'b0, total_reg} + (SUM_W + 1)'(head.product);
        less     = rd_data_reg < key_reg;
        lo_step  = less ? mid_reg + 1'b1 : lo_reg;
        hi_step  = less ? hi_reg : mid_reg;
        mid_step = lo_step + ((hi_step - lo_step) >> 1);
        lo_plus  = {1'b0, lo_step} + 1'b1;
    end

    always_comb
    begin
        state_next = state_reg;
        total_next = total_reg;
        count_next = count_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        key_next   = key_reg;
        done_next  = 1'b0;
        index_next = index_reg;
        pop        = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = '0;
        wr_en      = 1'b0;
        wr_addr    = count_reg[ADDR_W-1:0];
        wr_data    = sum[SUM_W] ? '1 : sum[SUM_W-1:0];
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    pop = 1'b1;
                    case (head.op)
                        OP_APPEND:
                        begin
                            if (count_reg < CNT_W'(MAX_SEGMENTS))
                            begin
                                wr_en      = 1'b1;
                                total_next = wr_data;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_QUERY:
                        begin
                            key_next = head.key;
                            if (head.key == '0)
                            begin
                                done_next  = 1'b1;
                                index_next = '0;
                            end
                            else if (count_reg == '0)
                            begin
                                done_next  = 1'b1;
                                index_next = IDX_W'(1);
                            end
                            else
                            begin
                                lo_next    = '0;
                                hi_next    = count_reg;
                                mid_next   = count_reg >> 1;
                                rd_en      = 1'b1;
                                rd_addr    = mid_next[ADDR_W-1:0];
                                state_next = ST_SEARCH;
                            end
                        end
                        OP_CLEAR:
                        begin
                            total_next = '0;
                            count_next = '0;
                        end
                        default:
                        begin
                            total_next = total_reg;
                        end
                    endcase
                end
            end
            ST_SEARCH:
            begin
                lo_next = lo_step;
                hi_next = hi_step;
                if (lo_step < hi_step)
                begin
                    mid_next = mid_step;
                    rd_en    = 1'b1;
                    rd_addr  = mid_step[ADDR_W-1:0];
                end
                else
                begin
                    done_next  = 1'b1;
                    index_next = IDX_W'(lo_plus);
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            total_reg <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            total_reg <= total_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        mid_reg   <= mid_next;
        key_reg   <= key_next;
        index_reg <= index_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // The stored count never passes the table depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_SEGMENTS))
        else $error("segment count beyond table depth");

    // While searching, the open interval is never empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH) |-> (lo_reg < hi_reg) && (hi_reg <= count_reg))
        else $error("search interval invalid");

    // A result never points past one beyond the last stored sum.
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ((CNT_W + 1)'(index_reg) <= ({1'b0, count_reg} + 1'b1)))
        else $error("result index out of range");

    // A new command is only taken from the queue while idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH) |-> !pop)
        else $error("queue popped during search");

endmodule

// ----- rtl/prefix_sum_lower_bound_search_core.sv -----
`timescale 1ns / 1ps
// ============================================================================
// prefix_sum_lower_bound_search_core
// Running prefix sum table with a lower bound binary search on query.
// ============================================================================
// A request is taken at a rising edge where start is high and busy is low.
// The mode port selects append, query or clear; the unused mode is dropped.
// An append adds play_count * segment_length to a saturating 48-bit total
// and stores it as the next prefix sum; appends beyond 1024 entries are
// ignored. A clear empties the table. Neither gives a result.
// A query returns one result: done is high for exactly one cycle with
// segment_index, the first entry whose prefix sum reaches query_minute.
// The receiver cannot stall; a result must be captured in its done cycle.
// Requests pass a decode stage and a two-entry queue, so busy rises only
// when both are full. An append or clear is carried out in the idle state
// of the search unit. A query passes the decode stage, starts the search
// from idle, then runs one binary search step per cycle with one table read
// each, up to 11 steps for a full table. A zero minute or an empty table
// gives its result from idle with no search. Reset empties the table; no
// clearing pass is needed.
// ============================================================================
module prefix_sum_lower_bound_search_core
    import psls_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [MODE_W-1:0] mode,
    input  logic [LEN_W-1:0]  play_count,
    input  logic [LEN_W-1:0]  segment_length,
    input  logic [SUM_W-1:0]  query_minute,
    output logic              done,
    output logic [IDX_W-1:0]  segment_index
);

    q_stat_t q_stat;
    logic    push;
    logic    pop;
    cmd_t    push_cmd;
    cmd_t    head;

    psls_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .mode           (mode),
        .play_count     (play_count),
        .segment_length (segment_length),
        .query_minute   (query_minute),
        .q_stat         (q_stat),
        .push           (push),
        .cmd            (push_cmd)
    );

    psls_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .q_stat   (q_stat)
    );

    psls_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .q_stat        (q_stat),
        .pop           (pop),
        .done          (done),
        .segment_index (segment_index)
    );

endmodule
